/* src/srg_pkg.sv */
//------------------------------------------------------------------------------
// srg_pkg
// Shared types and constants for the group-reversing stream block.
//------------------------------------------------------------------------------
package srg_pkg;

	localparam int MAX_GROUP_DEF = 16;
	localparam int VALUE_W       = 32;
	localparam int GS_W          = 5;
	localparam logic [GS_W-1:0] GS_RESET = 5'd2;

	typedef logic signed [VALUE_W-1:0] value_t;

	// movement of the cell chain for the current cycle
	typedef enum logic [1:0] {
		SHIFT_HOLD,
		SHIFT_RIGHT,
		SHIFT_LEFT
	} shift_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REV,
		ST_FWD
	} state_t;

endpackage

/* src/srg_stream_if.sv */
//------------------------------------------------------------------------------
// srg_stream_if
// Valid/ready channels for input items and reordered results.
//------------------------------------------------------------------------------
interface srg_item_if;
	logic            valid;
	logic            ready;
	srg_pkg::value_t value;
	logic            list_end;

	modport source (output valid, output value, output list_end, input ready);
	modport sink (input valid, input value, input list_end, output ready);
endinterface

interface srg_result_if;
	logic            valid;
	logic            ready;
	srg_pkg::value_t out_value;
	logic            run_last;
	logic            out_list_end;

	modport source (output valid, output out_value, output run_last,
		output out_list_end, input ready);
	modport sink (input valid, input out_value, input run_last,
		input out_list_end, output ready);
endinterface

/* src/srg_cell.sv */
//------------------------------------------------------------------------------
// srg_cell
// One storage cell of the chain; moves its word left, right or holds it.
//------------------------------------------------------------------------------
module srg_cell (
	input  logic            clk,
	input  srg_pkg::shift_t mode,
	input  srg_pkg::value_t from_left,
	input  srg_pkg::value_t from_right,
	output srg_pkg::value_t data
);

	srg_pkg::value_t data_q;

	always_ff @(posedge clk) begin
		case (mode)
			srg_pkg::SHIFT_RIGHT: data_q <= from_left;
			srg_pkg::SHIFT_LEFT:  data_q <= from_right;
			default:              data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

/* src/srg_ctrl.sv */
//------------------------------------------------------------------------------
// srg_ctrl
// Group sequencer: counts the fill, steers the chain and drives the result register.
//------------------------------------------------------------------------------
module srg_ctrl #(
	parameter int MAX_GROUP = srg_pkg::MAX_GROUP_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [srg_pkg::GS_W-1:0] cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    in_list_end,
	input  srg_pkg::value_t         head_data,
	input  srg_pkg::value_t         tail_data,
	output srg_pkg::shift_t         mode,
	output logic                    out_valid,
	input  logic                    out_ready,
	output srg_pkg::value_t         out_value,
	output logic                    out_run_last,
	output logic                    out_list_end
);

	localparam int CNT_W = $clog2(MAX_GROUP + 1);
	localparam int IDX_W = $clog2(MAX_GROUP);
	localparam logic [IDX_W-1:0] TAIL_IDX = IDX_W'(MAX_GROUP - 1);
	localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

	srg_pkg::state_t state_q, state_nxt;

	logic [srg_pkg::GS_W-1:0] group_size_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] remain_q;
	logic [IDX_W-1:0] head_q;
	logic             end_flag_q;
	logic             ov_q;
	srg_pkg::value_t  ov_value_q;
	logic             ov_last_q;
	logic             ov_end_q;

	logic [CNT_W-1:0] k_eff;
	logic [CNT_W-1:0] n_new;
	logic             in_fire;
	logic             can_emit;
	logic             at_tail;
	logic             emit;
	srg_pkg::value_t  emit_value;

	always_comb begin
		if (group_size_q == '0) begin
			k_eff = ONE;
		end else if (32'(group_size_q) > MAX_GROUP) begin
			k_eff = CNT_W'(MAX_GROUP);
		end else begin
			k_eff = CNT_W'(group_size_q);
		end
	end

	assign n_new    = fill_q + ONE;
	assign in_fire  = in_valid && in_ready;
	assign can_emit = !ov_q || out_ready;
	assign at_tail  = (head_q == TAIL_IDX);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			srg_pkg::ST_IDLE: begin
				if (in_fire) begin
					if (n_new >= k_eff) begin
						state_nxt = srg_pkg::ST_REV;
					end else if (in_list_end) begin
						state_nxt = srg_pkg::ST_FWD;
					end
				end
			end
			srg_pkg::ST_REV: begin
				if (can_emit && remain_q == ONE) begin
					state_nxt = srg_pkg::ST_IDLE;
				end
			end
			srg_pkg::ST_FWD: begin
				if (at_tail && can_emit && remain_q == ONE) begin
					state_nxt = srg_pkg::ST_IDLE;
				end
			end
			default: state_nxt = srg_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready   = 1'b0;
		mode       = srg_pkg::SHIFT_HOLD;
		emit       = 1'b0;
		emit_value = head_data;
		case (state_q)
			srg_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					mode = srg_pkg::SHIFT_RIGHT;
				end
			end
			srg_pkg::ST_REV: begin
				// newest sits in cell 0, pop it and pull the rest toward it
				if (can_emit) begin
					emit = 1'b1;
					mode = srg_pkg::SHIFT_LEFT;
				end
			end
			srg_pkg::ST_FWD: begin
				// walk the oldest beat to the far end, then drain from there
				emit_value = tail_data;
				if (!at_tail) begin
					mode = srg_pkg::SHIFT_RIGHT;
				end else if (can_emit) begin
					emit = 1'b1;
					mode = srg_pkg::SHIFT_RIGHT;
				end
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= srg_pkg::ST_IDLE;
			group_size_q <= srg_pkg::GS_RESET;
			fill_q       <= '0;
			remain_q     <= '0;
			head_q       <= '0;
			end_flag_q   <= 1'b0;
			ov_q         <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				group_size_q <= cfg_data;
			end
			if (in_fire) begin
				end_flag_q <= in_list_end;
				remain_q   <= n_new;
				head_q     <= IDX_W'(fill_q);
				if (n_new >= k_eff || in_list_end) begin
					fill_q <= '0;
				end else begin
					fill_q <= n_new;
				end
			end else if (state_q == srg_pkg::ST_FWD && !at_tail) begin
				head_q <= head_q + IDX_W'(1);
			end
			if (emit) begin
				remain_q <= remain_q - ONE;
				ov_q     <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			ov_value_q <= emit_value;
			ov_last_q  <= (remain_q == ONE);
			ov_end_q   <= (remain_q == ONE) && end_flag_q;
		end
	end

	assign out_valid    = ov_q;
	assign out_value    = ov_value_q;
	assign out_run_last = ov_last_q;
	assign out_list_end = ov_end_q;

endmodule

/* src/stream_reverse_in_groups.sv */
//------------------------------------------------------------------------------
// stream_reverse_in_groups
// Reorders a list stream in groups of group_size beats, held in a chain of cells.
//------------------------------------------------------------------------------
//  channel  | direction | payload                              | handshake
//  item     | in        | value, list_end                      | valid/ready
//  result   | out       | out_value, run_last, out_list_end    | valid/ready
//  cfg      | in        | cfg_data (group_size)                | cfg_we, no ready
//
// A beat that leaves its group incomplete is only shifted into cell 0. A beat that
// completes a group of n is followed by n pops of cell 0, newest first. A list end
// on a partial group of n first moves the oldest beat to the last cell, then drains
// the n beats from there, oldest first. One beat is worked at a time.
// Reset clears the fill count and loads group_size = 2; stalls on result only hold.
//------------------------------------------------------------------------------
module stream_reverse_in_groups #(
	parameter int MAX_GROUP = srg_pkg::MAX_GROUP_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [srg_pkg::GS_W-1:0] cfg_data,
	srg_item_if.sink                 item,
	srg_result_if.source             result
);

	srg_pkg::value_t cell_data [MAX_GROUP];
	srg_pkg::shift_t mode;

	srg_ctrl #(
		.MAX_GROUP (MAX_GROUP)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.in_valid     (item.valid),
		.in_ready     (item.ready),
		.in_list_end  (item.list_end),
		.head_data    (cell_data[0]),
		.tail_data    (cell_data[MAX_GROUP-1]),
		.mode         (mode),
		.out_valid    (result.valid),
		.out_ready    (result.ready),
		.out_value    (result.out_value),
		.out_run_last (result.run_last),
		.out_list_end (result.out_list_end)
	);

	for (genvar i = 0; i < MAX_GROUP; i++) begin : g_cell
		srg_pkg::value_t left_w, right_w;
		if (i == 0) begin : g_first
			assign left_w = item.value;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end
		if (i == MAX_GROUP - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end
		srg_cell u_cell (
			.clk        (clk),
			.mode       (mode),
			.from_left  (left_w),
			.from_right (right_w),
			.data       (cell_data[i])
		);
	end

endmodule
